[rtl/lhpq_pkg.sv]
`default_nettype none
package lhpq_pkg;
   localparam int KEY_W = 32;
   localparam int NPL_W = 5;
   localparam int IDX_W = 11;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEL_RD,
      S_DEL_WT,
      S_M_RD,
      S_M_WT,
      S_M_STEP,
      S_U_RD,
      S_U_WT,
      S_U_WR,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word
      logic do_clear;
      logic do_insert;  // allocate slot, write leaf, start merge
      logic del_read;   // issue read of root
      logic del_start;  // start merge of root's children
      logic m_read;     // read nodes a and b
      logic m_step;     // link winner back and advance
      logic m_done;     // one side ran out: latch merge result
      logic u_read;     // read parent node + npl of result and left
      logic u_write;    // write fixed parent
      logic fin_empty;
      logic fin_full;
      logic fin_plain;
      logic fin_merge;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] func;
      logic       full;
      logic       root_null;
      logic       merge_done;
      logic       unwind_done;
   } stat_type;
endpackage
`default_nettype wire

[rtl/lhpq_if.sv]
`default_nettype none
interface lhpq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic signed [31:0] new_key;
   modport source (output valid, func, new_key, input ready);
   modport sink (input valid, func, new_key, output ready);
endinterface

interface lhpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic signed [31:0] removed_key;
   logic [10:0] root_index;
   modport source (output valid, status, removed_key, root_index, input ready);
   modport sink (input valid, status, removed_key, root_index, output ready);
endinterface
`default_nettype wire

[rtl/leftist_heap_priority_queue.sv]
`default_nettype none
// Leftist-heap min-priority queue over a pool of CAPACITY node slots.
// req channel: one word per operation (func: insert new_key, delete-min,
//   clear). rsp channel: one word per request with status, removed_key
//   and root_index (pool slot of the root afterwards, 0 when empty).
// One request is in flight at a time: req_ready is high only while idle.
// Clear, no-op, rejected inserts and empty deletes go from the dispatch
//   state straight to the response. An insert or delete walks the two
//   right spines, reading, waiting and linking at each merge-path node,
//   then unwinds the path, reading, waiting and writing at each node,
//   fixing child order and distances.
// Reset clears the root and the slot count; pool contents need no clear
//   because a slot is only read after an insert wrote it.
// A stalled receiver holds the response word stable and blocks new
//   requests until it is taken. Slots are not reused before a clear.
module leftist_heap_priority_queue
   import lhpq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire         clock,
   input  wire         reset,
   lhpq_req_if.sink    req,
   lhpq_rsp_if.source  rsp
);
   cmd_type  cmd;
   stat_type stat;

   lhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lhpq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_func     (req.func),
      .in_key      (req.new_key),
      .out_status  (rsp.status),
      .out_removed (rsp.removed_key),
      .out_root    (rsp.root_index)
   );

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request taken while busy");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_EMPTY |-> rsp.root_index == '0)
      else $error("empty status with nonzero root");
   a_removed: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_OK |-> rsp.removed_key == '0)
      else $error("removed key on failure");
endmodule
`default_nettype wire

[rtl/lhpq_ctrl.sv]
`default_nettype none
module lhpq_ctrl
   import lhpq_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   input  wire       req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire       rsp_ready,
   input  stat_type  stat,
   output cmd_type   cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEL_RD;
            end
         end
         S_DEL_RD: begin
            // dispatch on the captured word
            unique case (func_type'(stat.func))
               FUNC_INSERT: begin
                  if (stat.full) begin
                     cmd.fin_full = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     cmd.do_insert = 1'b1;
                     state_in = S_M_RD;
                  end
               end
               FUNC_DELETE: begin
                  if (stat.root_null) begin
                     cmd.fin_empty = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     cmd.del_read = 1'b1;
                     state_in = S_DEL_WT;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  cmd.fin_plain = 1'b1;
                  state_in = S_DONE;
               end
               default: begin
                  cmd.fin_plain = 1'b1;
                  state_in = S_DONE;
               end
            endcase
         end
         S_DEL_WT: begin
            cmd.del_start = 1'b1;
            state_in = S_M_RD;
         end
         S_M_RD: begin
            if (stat.merge_done) begin
               cmd.m_done = 1'b1;
               state_in = S_U_RD;
            end else begin
               cmd.m_read = 1'b1;
               state_in = S_M_WT;
            end
         end
         S_M_WT: state_in = S_M_STEP;
         S_M_STEP: begin
            cmd.m_step = 1'b1;
            state_in = S_M_RD;
         end
         S_U_RD: begin
            if (stat.unwind_done) begin
               cmd.fin_merge = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.u_read = 1'b1;
               state_in = S_U_WT;
            end
         end
         S_U_WT: state_in = S_U_WR;
         S_U_WR: begin
            cmd.u_write = 1'b1;
            state_in = S_U_RD;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[rtl/lhpq_dpath.sv]
`default_nettype none
module lhpq_dpath
   import lhpq_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire               clock,
   input  wire               reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  wire [1:0]         in_func,
   input  wire [KEY_W-1:0]   in_key,
   output logic [1:0]        out_status,
   output logic [KEY_W-1:0]  out_removed,
   output logic [IDX_W-1:0]  out_root
);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int DEPTH = CAPACITY + 1;

   // node pool memories, one write port and registered reads
   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [PW-1:0]    lc_mem  [DEPTH];
   logic [PW-1:0]    rc_mem  [DEPTH];
   logic [NPL_W-1:0] npl_mem [DEPTH];

   logic [1:0]       func_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PW-1:0]    root_ff, root_in;
   logic [PW:0]      used_ff, used_in;
   logic [PW-1:0]    a_ff, a_in, b_ff, b_in, par_ff, par_in, res_ff, res_in;
   logic [1:0]       status_ff, status_in;
   logic [KEY_W-1:0] removed_ff, removed_in;

   // read port 1: node a / parent / root; port 2: node b / result npl
   logic [PW-1:0]    ra1, ra2;
   logic [KEY_W-1:0] k1_ff, k2_ff;
   logic [PW-1:0]    l1_ff, r1_ff;
   logic [NPL_W-1:0] n2_ff;

   // right child of b is needed when b wins; b's link is read with a's
   logic [PW-1:0]    rb_ff;

   // write port (one address, per-field enables)
   logic             we_k, we_l, we_r, we_n;
   logic [PW-1:0]    wa, wl, wr;
   logic [KEY_W-1:0] wk;
   logic [NPL_W-1:0] wn;

   logic             a_wins;
   logic [PW-1:0]    win, lose;
   logic [PW-1:0]    u_l, u_rr;

   always_comb begin
      ra1 = cmd.u_read ? par_ff : a_ff;
      ra2 = b_ff;
      if (cmd.u_read) ra2 = res_ff;
      if (cmd.del_read) ra1 = root_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.m_read || cmd.u_read || cmd.del_read) begin
         k1_ff <= key_mem[ra1];
         l1_ff <= lc_mem[ra1];
         r1_ff <= rc_mem[ra1];
         k2_ff <= key_mem[ra2];
         n2_ff <= (ra2 == '0) ? '0 : npl_mem[ra2];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.m_read) rb_ff <= rc_mem[b_ff];
   end

   // left-child distance needs its own read; taken in the wait cycle
   logic [NPL_W-1:0] nl_ff;
   always_ff @(posedge clock) begin
      nl_ff <= (l1_ff == '0) ? '0 : npl_mem[l1_ff];
   end

   // merge compare: b wins only when strictly smaller (signed)
   always_comb begin
      a_wins = !($signed(k2_ff) < $signed(k1_ff));
      win    = a_wins ? a_ff : b_ff;
      lose   = a_wins ? b_ff : a_ff;
   end

   // unwind fix: result becomes right child unless it is deeper than left
   always_comb begin
      u_l  = l1_ff;
      u_rr = res_ff;
      if (n2_ff > nl_ff) begin
         u_l  = res_ff;
         u_rr = l1_ff;
      end
   end

   always_comb begin
      we_k = 1'b0; we_l = 1'b0; we_r = 1'b0; we_n = 1'b0;
      wa = '0; wk = in_key; wl = '0; wr = '0; wn = '0;
      if (cmd.do_insert) begin
         wa = used_ff[PW-1:0] + 1'b1;
         we_k = 1'b1; we_l = 1'b1; we_r = 1'b1; we_n = 1'b1;
         wk = key_ff;
      end else if (cmd.m_step) begin
         // winner's right link points back at its parent
         wa = win; we_r = 1'b1; wr = par_ff;
      end else if (cmd.u_write) begin
         wa = par_ff; we_l = 1'b1; we_r = 1'b1; we_n = 1'b1;
         wl = u_l; wr = u_rr;
         wn = (u_rr == '0) ? '0 : ((u_rr == l1_ff) ? nl_ff : n2_ff) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we_k) key_mem[wa] <= wk;
      if (we_l) lc_mem[wa]  <= wl;
      if (we_r) rc_mem[wa]  <= wr;
      if (we_n) npl_mem[wa] <= wn;
   end

   always_comb begin
      root_in = root_ff; used_in = used_ff;
      a_in = a_ff; b_in = b_ff; par_in = par_ff; res_in = res_ff;
      status_in = status_ff; removed_in = removed_ff;
      if (cmd.load) begin
         status_in = ST_OK; removed_in = '0;
      end
      if (cmd.do_clear) begin
         root_in = '0; used_in = '0;
      end
      if (cmd.do_insert) begin
         used_in = used_ff + 1'b1;
         a_in = root_ff; b_in = used_ff[PW-1:0] + 1'b1; par_in = '0;
      end
      if (cmd.del_start) begin
         removed_in = k1_ff;
         a_in = l1_ff; b_in = r1_ff; par_in = '0;
      end
      if (cmd.m_step) begin
         par_in = win;
         a_in   = a_wins ? r1_ff : rb_ff;
         b_in   = lose;
      end
      if (cmd.m_done) begin
         res_in = (a_ff == '0) ? b_ff : a_ff;
      end
      if (cmd.u_write) begin
         res_in = par_ff;
         par_in = r1_ff;
      end
      if (cmd.fin_merge) root_in = res_ff;
      if (cmd.fin_empty) begin
         status_in = ST_EMPTY; root_in = '0;
      end
      if (cmd.fin_full) status_in = ST_FULL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
         used_ff <= '0;
      end else begin
         root_ff <= root_in;
         used_ff <= used_in;
      end
      if (cmd.load) begin
         func_ff <= in_func;
         key_ff  <= in_key;
      end
      a_ff <= a_in; b_ff <= b_in; par_ff <= par_in; res_ff <= res_in;
      status_ff <= status_in; removed_ff <= removed_in;
   end

   // merge_done is valid in the read state: one side ran out
   logic merge_end;
   assign merge_end = (a_ff == '0) || (b_ff == '0);

   always_comb begin
      stat.func        = func_ff;
      stat.full        = (used_ff >= (PW+1)'(CAPACITY));
      stat.root_null   = (root_ff == '0);
      stat.merge_done  = merge_end;
      stat.unwind_done = (par_ff == '0);
   end

   assign out_status  = status_ff;
   assign out_removed = removed_ff;
   assign out_root    = IDX_W'(root_ff);
endmodule
`default_nettype wire
